// ===== sv/kuf_pkg.sv =====
// Package: shared types and constants for the union-find MST engine.
`timescale 1ns / 1ps

package kuf_pkg;

  localparam int VERTEX_W = 10;
  localparam int LENGTH_W = 31;
  localparam int SUM_W    = 41;
  localparam int COUNT_W  = 10;
  localparam int VC_W     = 11;

  localparam logic [VC_W-1:0] VC_RESET = 11'd1024;

  typedef struct packed {
    logic                start_graph;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
    logic [LENGTH_W-1:0] edge_length;
  } kuf_in_t;

  typedef struct packed {
    logic               edge_taken;
    logic [SUM_W-1:0]   total_length;
    logic [COUNT_W-1:0] taken_count;
    logic               tree_complete;
    logic               index_error;
  } kuf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_WALK_A,
    ST_WALK_B,
    ST_MERGE
  } kuf_state_t;

endpackage

// ===== sv/kuf_parent_ram.sv =====
// Parent store: single-port-write, registered-read memory.
`timescale 1ns / 1ps

module kuf_parent_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/kruskal_union_find_engine.sv =====
// Top level: Kruskal MST edge filter with union-find by size over a parent memory.
`timescale 1ns / 1ps

// One edge is taken per start/busy transfer; one result follows per edge on out_strobe,
// held for a single cycle, and the receiver cannot stall it. Each edge passes a check
// state, then, if in range and before completion, a memory read per link on each
// endpoint's root walk (depth at most about log2 of the vertex count, plus the root)
// and a merge write if the roots differ. An edge with start_graph set first sweeps the
// whole parent memory back to -1, one entry per cycle; the same sweep runs after reset,
// with busy high throughout. The user writes vertex_count through cfg_we/cfg_wdata only
// while busy is low and no result is pending; the block itself does not enforce this.

module kruskal_union_find_engine #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  kuf_pkg::kuf_in_t            in_data,
  output logic                        out_strobe,
  output kuf_pkg::kuf_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [kuf_pkg::VC_W-1:0]    cfg_wdata
);

  import kuf_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW = AW + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

  kuf_state_t         state_r, state_nxt;
  kuf_in_t            item_r, item_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [VC_W-1:0]    vc_r;
  logic [AW-1:0]      clr_ptr_r, clr_ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [AW-1:0]      ra_r, ra_nxt;
  logic signed [PW-1:0] sa_r, sa_nxt;
  logic [AW-1:0]      lose_r, lose_nxt;
  logic [AW-1:0]      win_r, win_nxt;
  logic               out_valid_r, out_valid_nxt;
  kuf_out_t           out_r, out_nxt;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [PW-1:0]      rd_data;
  logic signed [PW-1:0] rd_s;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [PW-1:0]      wr_data;

  logic [VC_W-1:0]    n_eff;
  logic               err;
  logic               complete;
  logic [AW-1:0]      a_idx, b_idx;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic signed [PW-1:0] size_sum;

  kuf_parent_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .DW    (PW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign rd_s = rd_data;

  always_comb begin
    n_eff = ((32'(vc_r)) > (32'(MAX_VERTICES))) ? VC_W'(MAX_VERTICES) : vc_r;
    err = ({1'b0, item_r.from_vertex} >= n_eff) || ({1'b0, item_r.to_vertex} >= n_eff);
    complete = (n_eff <= 11'd1) || ({1'b0, cnt_r} >= (n_eff - 11'd1));
    a_idx = AW'(item_r.from_vertex);
    b_idx = AW'(item_r.to_vertex);
    sum_add = {1'b0, sum_r} + (SUM_W + 1)'(item_r.edge_length);
    sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    size_sum = sa_r + rd_s;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    clr_ptr_nxt   = clr_ptr_r;
    pend_nxt      = pend_r;
    cur_nxt       = cur_r;
    ra_nxt        = ra_r;
    sa_nxt        = sa_r;
    lose_nxt      = lose_r;
    win_nxt       = win_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = cur_r;
    wr_en         = 1'b0;
    wr_addr       = clr_ptr_r;
    wr_data       = {PW{1'b1}};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          if (in_data.start_graph) begin
            state_nxt   = ST_CLEAR;
            clr_ptr_nxt = '0;
            pend_nxt    = 1'b1;
            sum_nxt     = '0;
            cnt_nxt     = '0;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_ptr_r;
        wr_data     = {PW{1'b1}};
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == LAST_ADDR) begin
          state_nxt = pend_r ? ST_CHECK : ST_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      ST_CHECK: begin
        if (err || complete) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{edge_taken: 1'b0, total_length: sum_r, taken_count: cnt_r,
                      tree_complete: complete, index_error: err};
          state_nxt = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = a_idx;
          cur_nxt   = a_idx;
          state_nxt = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        rd_en = 1'b1;
        if (!rd_s[PW-1]) begin
          rd_addr = rd_data[AW-1:0];
          cur_nxt = rd_data[AW-1:0];
        end else begin
          ra_nxt    = cur_r;
          sa_nxt    = rd_s;
          rd_addr   = b_idx;
          cur_nxt   = b_idx;
          state_nxt = ST_WALK_B;
        end
      end
      ST_WALK_B: begin
        if (!rd_s[PW-1]) begin
          rd_en   = 1'b1;
          rd_addr = rd_data[AW-1:0];
          cur_nxt = rd_data[AW-1:0];
        end else if (cur_r == ra_r) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{edge_taken: 1'b0, total_length: sum_r, taken_count: cnt_r,
                      tree_complete: complete, index_error: 1'b0};
          state_nxt = ST_IDLE;
        end else begin
          wr_en   = 1'b1;
          wr_data = size_sum;
          if (sa_r <= rd_s) begin
            wr_addr  = ra_r;
            win_nxt  = ra_r;
            lose_nxt = cur_r;
          end else begin
            wr_addr  = cur_r;
            win_nxt  = cur_r;
            lose_nxt = ra_r;
          end
          sum_nxt   = sum_sat;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        wr_en         = 1'b1;
        wr_addr       = lose_r;
        wr_data       = {1'b0, win_r};
        out_valid_nxt = 1'b1;
        out_nxt = '{edge_taken: 1'b1, total_length: sum_r, taken_count: cnt_r,
                    tree_complete: complete, index_error: 1'b0};
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_ptr_r   <= '0;
      pend_r      <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      pend_r      <= pend_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else if (cfg_we) begin
      vc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    cur_r  <= cur_nxt;
    ra_r   <= ra_nxt;
    sa_r   <= sa_nxt;
    lose_r <= lose_nxt;
    win_r  <= win_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

endmodule

// ===== dv/kruskal_union_find_engine_tb.sv =====
// Testbench: feeds edge streams into the union-find MST engine and checks each result transfer.
`timescale 1ns / 1ps
module kruskal_union_find_engine_tb;
  import kuf_pkg::*;

  localparam int MAX_VERTICES = 1024;
  localparam int unsigned LENGTH_MAX = 32'h7FFF_FFFF;
  localparam int EDGE_TARGET = 622;

  class mst_scoreboard #(int STORE_DEPTH = 1024);
    int                 parent_link[STORE_DEPTH];
    logic [SUM_W-1:0]   length_total;
    logic [COUNT_W-1:0] edges_joined;
    logic [VC_W-1:0]    vertex_count;
    kuf_out_t           expected_results[$];
    int                 mismatches;
    int                 checked;

    function new();
      vertex_count = VC_RESET;
      mismatches = 0;
      checked = 0;
      clear_forest();
    endfunction

    function void clear_forest();
      foreach (parent_link[i]) parent_link[i] = -1;
      length_total = '0;
      edges_joined = '0;
    endfunction

    function int root_of(int v);
      int steps;
      steps = 0;
      while (steps < STORE_DEPTH && parent_link[v] >= 0 && parent_link[v] < STORE_DEPTH) begin
        v = parent_link[v];
        steps++;
      end
      return v;
    endfunction

    function bit tree_done(int unsigned n);
      return (n <= 1) || (edges_joined >= n - 1);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_edge(kuf_in_t e);
      kuf_out_t         r;
      int unsigned      n;
      int               ra;
      int               rb;
      logic [SUM_W:0]   s;
      if (e.start_graph) clear_forest();
      n = (vertex_count > STORE_DEPTH) ? STORE_DEPTH : vertex_count;
      r = '0;
      r.index_error = (e.from_vertex >= n) || (e.to_vertex >= n);
      if (!r.index_error && !tree_done(n)) begin
        ra = root_of(e.from_vertex);
        rb = root_of(e.to_vertex);
        if (ra != rb) begin
          r.edge_taken = 1'b1;
          s = {1'b0, length_total} + e.edge_length;
          length_total = s[SUM_W] ? '1 : s[SUM_W-1:0];
          edges_joined = edges_joined + 1'b1;
          // union by size; on a tie the root of from_vertex stays root
          if (parent_link[ra] <= parent_link[rb]) begin
            parent_link[ra] += parent_link[rb];
            parent_link[rb] = ra;
          end else begin
            parent_link[rb] += parent_link[ra];
            parent_link[ra] = rb;
          end
        end
      end
      r.total_length  = length_total;
      r.taken_count   = edges_joined;
      r.tree_complete = tree_done(n);
      expected_results.insert(expected_results.size(), r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH result %0d %s: got %0h expected %0h", checked, what, got, want);
      mismatches++;
    endtask

    task check_result(kuf_out_t got);
      kuf_out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("transfer with no edge pending", got.total_length, 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.edge_taken !== want.edge_taken)
        report_mismatch("edge_taken", got.edge_taken, want.edge_taken);
      if (got.total_length !== want.total_length)
        report_mismatch("total_length", got.total_length, want.total_length);
      if (got.taken_count !== want.taken_count)
        report_mismatch("taken_count", got.taken_count, want.taken_count);
      if (got.tree_complete !== want.tree_complete)
        report_mismatch("tree_complete", got.tree_complete, want.tree_complete);
      if (got.index_error !== want.index_error)
        report_mismatch("index_error", got.index_error, want.index_error);
      checked++;
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  kuf_in_t         in_data;
  logic            out_strobe;
  kuf_out_t        out_data;
  logic            cfg_we;
  logic [VC_W-1:0] cfg_wdata;

  mst_scoreboard #(MAX_VERTICES) sb;
  int gap_pct;
  int edges_sent;
  int graphs_run;
  int count_writes;

  kruskal_union_find_engine #(
    .MAX_VERTICES(MAX_VERTICES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_result(out_data);
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_edge(input logic sg, input int a, input int b, input int unsigned len);
    kuf_in_t e;
    e.start_graph = sg;
    e.from_vertex = a[VERTEX_W-1:0];
    e.to_vertex   = b[VERTEX_W-1:0];
    e.edge_length = len[LENGTH_W-1:0];
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (busy);
    sb.note_edge(e);
    edges_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_vertex_count(input int v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[VC_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.vertex_count = v[VC_W-1:0];
    count_writes++;
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          roll;
    int          vc;
    int          n;
    int          edges;
    int          a;
    int          b;
    int          noise;
    bit          fresh;
    logic        sg;
    int unsigned length;
    int unsigned len_now;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    gap_pct = 0;
    edges_sent = 0;
    graphs_run = 0;
    count_writes = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    settle();

    // default vertex count, widest edge, repeat and self loop
    send_edge(1'b1, 0, 1023, LENGTH_MAX);
    send_edge(1'b0, 1023, 0, 0);
    send_edge(1'b0, 5, 5, 1);
    // empty graph: everything out of range
    write_vertex_count(0);
    send_edge(1'b1, 0, 0, 0);
    send_edge(1'b0, 1023, 1023, 2);
    // single vertex: complete from the start
    write_vertex_count(1);
    send_edge(1'b1, 0, 0, 3);
    send_edge(1'b0, 0, 1, 4);
    // two vertices: edges after completion are dropped, errors still flagged
    write_vertex_count(2);
    send_edge(1'b1, 0, 1, 10);
    send_edge(1'b0, 1, 0, 20);
    send_edge(1'b0, 0, 2, 30);
    // size ties on merge
    write_vertex_count(4);
    send_edge(1'b1, 0, 1, 3);
    send_edge(1'b0, 2, 3, 3);
    send_edge(1'b0, 3, 1, 4);
    send_edge(1'b0, 0, 2, 5);
    // grow and then shrink the graph without clearing
    write_vertex_count(8);
    send_edge(1'b0, 4, 5, 6);
    send_edge(1'b0, 6, 7, 7);
    send_edge(1'b0, 5, 0, 8);
    send_edge(1'b0, 7, 4, 9);
    write_vertex_count(3);
    send_edge(1'b0, 0, 2, 10);
    send_edge(1'b0, 3, 0, 11);
    // count above the store size
    write_vertex_count(2047);
    send_edge(1'b1, 1023, 512, LENGTH_MAX);
    send_edge(1'b0, 10'h2AA, 10'h155, 32'h2AAA_AAAA);

    while (edges_sent < EDGE_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 4) vc = $urandom_range(1, 0);
      else if (roll < 10) vc = $urandom_range(2047, 1024);
      else if (roll < 16) vc = $urandom_range(1023, 100);
      else vc = $urandom_range(40, 2);
      n = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
      gap_pct = (graphs_run % 3 == 1) ? 45 : (graphs_run % 3 == 2) ? 6 : 0;
      write_vertex_count(vc);
      fresh = ($urandom_range(9) != 0);
      edges = (n <= 40) ? $urandom_range(3 * n + 4, n) : $urandom_range(60, 20);
      length = $urandom_range(32'h7000_0000, 0);
      for (int k = 0; k < edges; k++) begin
        noise = $urandom_range(99);
        a = (n > 0) ? $urandom_range(n - 1, 0) : $urandom_range(1023, 0);
        b = (n > 0) ? $urandom_range(n - 1, 0) : $urandom_range(1023, 0);
        if (noise < 5) b = $urandom_range(1023, 0);
        if (noise < 3) a = $urandom_range(1023, 0);
        length = length + $urandom_range(1000, 0);
        len_now = (noise >= 95) ? ($urandom & LENGTH_MAX) : length;
        sg = (k == 0) ? fresh : (noise >= 5 && noise < 8);
        send_edge(sg, a, b, len_now);
      end
      graphs_run++;
    end

    settle();
    repeat (40) @(negedge clk);
    $display("Sent %0d edges over %0d random graphs; %0d results checked.",
             edges_sent, graphs_run, sb.checked);
    $display("Vertex count written %0d times, from empty graph to beyond the store.",
             count_writes);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
